### design/hih_pkg.sv
// Package for the Hall index homing sequencer: phase encoding, motor and
// event codes, the sequencer state and result records. No dependencies.
package hih_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned TIMEOUT_W = 31;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned SUM_W     = POS_W + 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10000);

  typedef enum logic [8:0] {
    PH_START     = 9'b000000001,
    PH_INIT      = 9'b000000010,
    PH_WAIT_LOW  = 9'b000000100,
    PH_FWD_LOW   = 9'b000001000,
    PH_FWD_HIGH  = 9'b000010000,
    PH_REV_LOW   = 9'b000100000,
    PH_REV_HIGH  = 9'b001000000,
    PH_INDEXED   = 9'b010000000,
    PH_ERROR     = 9'b100000000
  } phase_t;

  // Reported state codes.
  localparam logic [2:0] FS_START    = 3'd0;
  localparam logic [2:0] FS_INIT     = 3'd1;
  localparam logic [2:0] FS_WAIT_LOW = 3'd2;
  localparam logic [2:0] FS_FWD_LOW  = 3'd3;
  localparam logic [2:0] FS_FWD_HIGH = 3'd4;
  localparam logic [2:0] FS_REV_LOW  = 3'd5;
  localparam logic [2:0] FS_REV_HIGH = 3'd6;
  localparam logic [2:0] FS_INDEXED  = 3'd7;

  // Motor commands.
  localparam logic [2:0] MC_NONE        = 3'd0;
  localparam logic [2:0] MC_STOP        = 3'd1;
  localparam logic [2:0] MC_FORWARD     = 3'd2;
  localparam logic [2:0] MC_REVERSE     = 3'd3;
  localparam logic [2:0] MC_STOP_ROTATE = 3'd4;

  // Events.
  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_FOUND     = 2'd1;
  localparam logic [1:0] EV_NOT_FOUND = 2'd2;

  typedef struct packed {
    phase_t                    phase;
    logic                      init_pending;
    logic                      index_pending;
    logic [STAMP_W-1:0]        progress_stamp;
    logic signed [POS_W-1:0]   edge0;
    logic signed [POS_W-1:0]   edge1;
    logic signed [POS_W-1:0]   edge2;
    logic                      power_on;
  } hih_state_t;

  typedef struct packed {
    logic [2:0]              fsm_state;
    logic                    failed;
    logic [2:0]              motor_command;
    logic                    sensor_power;
    logic [1:0]              event_code;
    logic signed [POS_W-1:0] index_offset;
  } hih_result_t;

  // The error phase is reported as the start code, flagged by failed.
  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_START:    code = FS_START;
      PH_INIT:     code = FS_INIT;
      PH_WAIT_LOW: code = FS_WAIT_LOW;
      PH_FWD_LOW:  code = FS_FWD_LOW;
      PH_FWD_HIGH: code = FS_FWD_HIGH;
      PH_REV_LOW:  code = FS_REV_LOW;
      PH_REV_HIGH: code = FS_REV_HIGH;
      PH_INDEXED:  code = FS_INDEXED;
      default:     code = FS_START;
    endcase
    return code;
  endfunction

endpackage

### design/hih_if.sv
// Valid/ready channel interfaces for the homing sequencer: the tick item
// going in and the result item coming out. Depends on hih_pkg.
interface hih_in_if import hih_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    init_request;
  logic                    index_request;
  logic                    sensor_triggered;
  logic signed [POS_W-1:0] position;
  logic [STAMP_W-1:0]      now_ms;

  modport source (output valid, init_request, index_request, sensor_triggered,
                  position, now_ms, input ready);
  modport sink (input valid, init_request, index_request, sensor_triggered,
                position, now_ms, output ready);
endinterface

interface hih_out_if import hih_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              fsm_state;
  logic                    failed;
  logic [2:0]              motor_command;
  logic                    sensor_power;
  logic [1:0]              event_code;
  logic signed [POS_W-1:0] index_offset;

  modport source (output valid, fsm_state, failed, motor_command, sensor_power,
                  event_code, index_offset, input ready);
  modport sink (input valid, fsm_state, failed, motor_command, sensor_power,
                event_code, index_offset, output ready);
endinterface

### design/hih_step.sv
// Next-state and result logic for one tick of the homing sequencer.
// Purely combinational; depends on hih_pkg.
module hih_step import hih_pkg::*; (
  input  hih_state_t               state,
  input  logic [TIMEOUT_W-1:0]     timeout_ms,
  input  logic                     init_request,
  input  logic                     index_request,
  input  logic                     sensor_triggered,
  input  logic signed [POS_W-1:0]  position,
  input  logic [STAMP_W-1:0]       now_ms,
  output hih_state_t               state_next,
  output hih_result_t              result
);

  logic [STAMP_W-1:0]      elapsed;
  logic                    timed_out;
  logic                    want_high;
  logic signed [SUM_W-1:0] edge_sum;
  logic [2:0]              motor;
  logic [1:0]              event_out;
  logic signed [POS_W-1:0] offset;

  // Elapsed time is read as signed, so a stamp in the future never fails.
  assign elapsed   = now_ms - state.progress_stamp;
  assign timed_out = $signed({elapsed[STAMP_W-1], elapsed})
                     > $signed({2'b00, timeout_ms});
  assign want_high = (state.phase == PH_FWD_LOW) || (state.phase == PH_REV_LOW);
  assign edge_sum  = SUM_W'(state.edge0) + SUM_W'(state.edge1)
                   + SUM_W'(state.edge2) + SUM_W'(position);

  always_comb begin
    state_next = state;
    motor      = MC_NONE;
    event_out  = EV_NONE;
    offset     = '0;
    if (init_request) begin
      state_next.init_pending = 1'b1;
    end
    if (index_request) begin
      state_next.index_pending = 1'b1;
    end
    case (state.phase)
      PH_START: begin
        if (state_next.init_pending) begin
          state_next.init_pending = 1'b0;
          state_next.power_on     = 1'b0;
          state_next.phase        = PH_INIT;
          motor                   = MC_STOP;
        end
      end
      PH_INIT, PH_INDEXED, PH_ERROR: begin
        if (state_next.index_pending) begin
          state_next.index_pending  = 1'b0;
          state_next.power_on       = 1'b1;
          state_next.progress_stamp = now_ms;
          state_next.phase          = PH_WAIT_LOW;
          motor                     = MC_FORWARD;
        end
      end
      default: begin
        if (sensor_triggered == want_high) begin
          state_next.progress_stamp = now_ms;
          case (state.phase)
            PH_WAIT_LOW: begin
              state_next.phase = PH_FWD_LOW;
            end
            PH_FWD_LOW: begin
              state_next.edge0 = position;
              state_next.phase = PH_FWD_HIGH;
            end
            PH_FWD_HIGH: begin
              state_next.edge1 = position;
              state_next.phase = PH_REV_LOW;
              motor            = MC_REVERSE;
            end
            PH_REV_LOW: begin
              state_next.edge2 = position;
              state_next.phase = PH_REV_HIGH;
            end
            default: begin
              // Fourth edge: floor of the mean of the four captures.
              offset              = edge_sum[SUM_W-1:2];
              motor               = MC_STOP_ROTATE;
              event_out           = EV_FOUND;
              state_next.power_on = 1'b0;
              state_next.phase    = PH_INDEXED;
            end
          endcase
        end else if (timed_out) begin
          motor               = MC_STOP;
          event_out           = EV_NOT_FOUND;
          state_next.power_on = 1'b0;
          state_next.phase    = PH_ERROR;
        end
      end
    endcase
  end

  assign result.fsm_state     = phase_code(state_next.phase);
  assign result.failed        = (state_next.phase == PH_ERROR);
  assign result.motor_command = motor;
  assign result.sensor_power  = state_next.power_on;
  assign result.event_code    = event_out;
  assign result.index_offset  = offset;

endmodule

### design/hall_index_homing_fsm.sv
// Top level of the Hall index homing sequencer: state registers, timeout
// register and the result register. Depends on hih_pkg, hih_if, hih_step.
//
// Usage: each item on in_ch is one scheduler tick carrying the init and
// index requests, the Hall sensor level, the mount position (Q16.16
// degrees) and a millisecond timestamp. For every accepted item exactly one
// result item appears on out_ch, carrying the state after the tick, the
// motor command issued, the sensor power level, an event code and the
// homing offset on a found event.
// An item accepted at a clock edge has its result valid in the result
// register just after that edge. The block takes one item per cycle while
// results are being taken; the tick logic is a single pass through hih_step
// between the sequencer state and the result register.
// The input is ready whenever the result register is empty or being taken
// in the same cycle, so a stalled receiver holds the result in place and
// stops new items until it takes it; no result is dropped or repeated.
// The timeout register is written through cfg_write/cfg_data and should be
// changed only while no tick is in flight.
// Reset (rst, synchronous) returns the sequencer to the start state, clears
// the pending requests, the progress stamp and the captured edges, turns the
// sensor power flag off, empties the result register and loads the timeout
// with 10000 ms.
module hall_index_homing_fsm import hih_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [TIMEOUT_W-1:0]  cfg_data,
  hih_in_if.sink                in_ch,
  hih_out_if.source             out_ch
);

  hih_state_t           state;
  hih_state_t           state_next;
  hih_result_t          result_next;
  hih_result_t          result;
  logic                 result_valid;
  logic [TIMEOUT_W-1:0] timeout_ms;
  logic                 accept;

  assign in_ch.ready = !result_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  hih_step u_step (
    .state            (state),
    .timeout_ms       (timeout_ms),
    .init_request     (in_ch.init_request),
    .index_request    (in_ch.index_request),
    .sensor_triggered (in_ch.sensor_triggered),
    .position         (in_ch.position),
    .now_ms           (in_ch.now_ms),
    .state_next       (state_next),
    .result           (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      timeout_ms <= cfg_data;
    end
  end

  // Sequencer state advances only on an accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= PH_START;
      state.init_pending   <= 1'b0;
      state.index_pending  <= 1'b0;
      state.progress_stamp <= '0;
      state.edge0          <= '0;
      state.edge1          <= '0;
      state.edge2          <= '0;
      state.power_on       <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register: loads on accept, empties when taken without a refill.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (out_ch.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign out_ch.valid         = result_valid;
  assign out_ch.fsm_state     = result.fsm_state;
  assign out_ch.failed        = result.failed;
  assign out_ch.motor_command = result.motor_command;
  assign out_ch.sensor_power  = result.sensor_power;
  assign out_ch.event_code    = result.event_code;
  assign out_ch.index_offset  = result.index_offset;

endmodule

### design/hih_checker.sv
// Port-level checks for the homing sequencer, bound to the top level.
// Depends on hih_pkg and hall_index_homing_fsm.
module hih_checker import hih_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [2:0]              fsm_state,
  input logic                    failed,
  input logic [2:0]              motor_command,
  input logic                    sensor_power,
  input logic [1:0]              event_code,
  input logic signed [POS_W-1:0] index_offset
);

  // A stalled result item keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(index_offset)
      && $stable(fsm_state) && $stable(motor_command))
    else $error("result item changed while stalled");

  // An empty result register never holds back the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Every accepted item yields a result in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // A found event stops the motor with a rotate to zero and ends indexed.
  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code == EV_FOUND |->
      motor_command == MC_STOP_ROTATE && fsm_state == FS_INDEXED
      && !sensor_power && !failed)
    else $error("inconsistent found event");

  // A not-found event stops the motor and enters the error state.
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code == EV_NOT_FOUND |->
      motor_command == MC_STOP && failed && !sensor_power
      && fsm_state == FS_START && index_offset == '0)
    else $error("inconsistent not-found event");

endmodule

bind hall_index_homing_fsm hih_checker u_hih_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .fsm_state     (out_ch.fsm_state),
  .failed        (out_ch.failed),
  .motor_command (out_ch.motor_command),
  .sensor_power  (out_ch.sensor_power),
  .event_code    (out_ch.event_code),
  .index_offset  (out_ch.index_offset)
);

### sim/tb_hall_index_homing_fsm.sv
// Testbench for hall_index_homing_fsm: sends scheduler ticks and checks each
// result against a predictor of the homing sequence kept in this file.
// Depends on hih_pkg, the hih_in_if/hih_out_if interfaces and the design.
module tb_hall_index_homing_fsm;
  import hih_pkg::*;

  // One scheduler tick as it goes onto the input channel.
  typedef struct packed {
    logic                    init_request;
    logic                    index_request;
    logic                    sensor_triggered;
    logic signed [POS_W-1:0] position;
    logic [STAMP_W-1:0]      now_ms;
  } tick_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [TIMEOUT_W-1:0] cfg_data;

  hih_in_if  in_ch ();
  hih_out_if out_ch ();

  hall_index_homing_fsm u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Predicted copy of the sequencer: phase, latched requests, the stamp of
  // the last progress, the captured edge positions, sensor power and the
  // timeout register.
  phase_t                  mount_phase;
  logic                    init_held;
  logic                    index_held;
  logic [STAMP_W-1:0]      last_progress_ms;
  logic signed [POS_W-1:0] captured_pos [4];
  logic                    sensor_on;
  logic [TIMEOUT_W-1:0]    timeout_limit;

  // Results still owed by the block, oldest first.
  hih_result_t expected_reports [$];

  int          mismatches;
  int          ticks_sent;
  int          found_seen;
  int          lost_seen;
  int          burst_left;
  bit          hold_req;
  logic [31:0] clock_ms;

  task automatic reset_model();
    mount_phase      = PH_START;
    init_held        = 1'b0;
    index_held       = 1'b0;
    last_progress_ms = '0;
    captured_pos     = '{default: '0};
    sensor_on        = 1'b0;
    timeout_limit    = TIMEOUT_RESET;
  endtask

  // Advance the predicted sequencer by one tick and return the result item
  // that the block must report for it.
  function automatic hih_result_t predict_tick(input tick_t t);
    hih_result_t              r;
    logic                     want_level;
    logic signed [STAMP_W-1:0] elapsed;
    logic signed [SUM_W-1:0]  edge_sum;
    r = '0;
    r.motor_command = MC_NONE;
    r.event_code    = EV_NONE;
    // Requests are latched first, so a phase can consume them in this tick.
    if (t.init_request) init_held = 1'b1;
    if (t.index_request) index_held = 1'b1;
    case (mount_phase)
      PH_START: begin
        if (init_held) begin
          init_held       = 1'b0;
          r.motor_command = MC_STOP;
          sensor_on       = 1'b0;
          mount_phase     = PH_INIT;
        end
      end
      PH_INIT, PH_INDEXED, PH_ERROR: begin
        if (index_held) begin
          index_held       = 1'b0;
          r.motor_command  = MC_FORWARD;
          sensor_on        = 1'b1;
          last_progress_ms = t.now_ms;
          mount_phase      = PH_WAIT_LOW;
        end
      end
      default: begin
        // The two "low" phases wait for the sensor to rise, the others for
        // it to fall.
        want_level = (mount_phase == PH_FWD_LOW) || (mount_phase == PH_REV_LOW);
        elapsed    = t.now_ms - last_progress_ms;
        if (t.sensor_triggered == want_level) begin
          last_progress_ms = t.now_ms;
          case (mount_phase)
            PH_WAIT_LOW: mount_phase = PH_FWD_LOW;
            PH_FWD_LOW: begin
              captured_pos[0] = t.position;
              mount_phase     = PH_FWD_HIGH;
            end
            PH_FWD_HIGH: begin
              captured_pos[1] = t.position;
              r.motor_command = MC_REVERSE;
              mount_phase     = PH_REV_LOW;
            end
            PH_REV_LOW: begin
              captured_pos[2] = t.position;
              mount_phase     = PH_REV_HIGH;
            end
            default: begin
              captured_pos[3] = t.position;
              edge_sum = captured_pos[0] + captured_pos[1] + captured_pos[2] +
                         captured_pos[3];
              // Floor of the mean: arithmetic shift of the wide sum.
              r.index_offset  = POS_W'(edge_sum >>> 2);
              r.motor_command = MC_STOP_ROTATE;
              r.event_code    = EV_FOUND;
              sensor_on       = 1'b0;
              mount_phase     = PH_INDEXED;
            end
          endcase
        end else if (elapsed > $signed({2'b00, timeout_limit})) begin
          // A negative elapsed time is never a timeout.
          r.motor_command = MC_STOP;
          r.event_code    = EV_NOT_FOUND;
          sensor_on       = 1'b0;
          mount_phase     = PH_ERROR;
        end
      end
    endcase
    case (mount_phase)
      PH_INIT:     r.fsm_state = FS_INIT;
      PH_WAIT_LOW: r.fsm_state = FS_WAIT_LOW;
      PH_FWD_LOW:  r.fsm_state = FS_FWD_LOW;
      PH_FWD_HIGH: r.fsm_state = FS_FWD_HIGH;
      PH_REV_LOW:  r.fsm_state = FS_REV_LOW;
      PH_REV_HIGH: r.fsm_state = FS_REV_HIGH;
      PH_INDEXED:  r.fsm_state = FS_INDEXED;
      default:     r.fsm_state = FS_START;
    endcase
    r.failed       = (mount_phase == PH_ERROR);
    r.sensor_power = sensor_on;
    return r;
  endfunction

  function automatic tick_t make_tick(input logic init_req, input logic index_req,
                                      input logic level, input logic [31:0] pos,
                                      input logic [31:0] now);
    tick_t t;
    t.init_request     = init_req;
    t.index_request    = index_req;
    t.sensor_triggered = level;
    t.position         = pos;
    t.now_ms           = now;
    return t;
  endfunction

  // Send one tick. The sender runs in bursts; at the start of each burst it
  // may drop valid for a random gap. The expectation is formed at the edge
  // where the block takes the item.
  task automatic send_tick(input tick_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(50, 150);
      end else begin
        burst_left = $urandom_range(1, 20);
      end
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid            <= 1'b1;
    in_ch.init_request     <= t.init_request;
    in_ch.index_request    <= t.index_request;
    in_ch.sensor_triggered <= t.sensor_triggered;
    in_ch.position         <= t.position;
    in_ch.now_ms           <= t.now_ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_reports.push_back(predict_tick(t));
    ticks_sent++;
  endtask

  // Stop offering ticks until every owed result has been taken.
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The timeout register is only written while nothing is in flight.
  task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
    pause_until_drained();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write     <= 1'b0;
    timeout_limit = value;
  endtask

  // A tick shaped by the predicted phase: mostly the sensor level that makes
  // progress, so that runs reach the found event, with wrong levels, time
  // jumps and backward steps mixed in to provoke timeouts.
  task automatic send_random_tick(input logic [31:0] step_max);
    tick_t t;
    logic  want_level;
    logic  idle_phase;
    int    dice;
    want_level = (mount_phase == PH_FWD_LOW) || (mount_phase == PH_REV_LOW);
    idle_phase = (mount_phase == PH_INIT) || (mount_phase == PH_INDEXED) ||
                 (mount_phase == PH_ERROR) || (mount_phase == PH_START);
    dice = $urandom_range(0, 99);
    if (dice < 85) begin
      clock_ms = clock_ms + $urandom_range(0, step_max);
    end else if (dice < 93) begin
      clock_ms = clock_ms + step_max * $urandom_range(1, 4);
    end else if (dice < 97) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms - $urandom_range(1, 5000);
    end
    t.now_ms       = clock_ms;
    t.init_request = ($urandom_range(0, 31) == 0);
    if (idle_phase) begin
      t.index_request = ($urandom_range(0, 2) == 0);
    end else begin
      t.index_request = ($urandom_range(0, 19) == 0);
    end
    if ($urandom_range(0, 3) != 0) begin
      t.sensor_triggered = want_level;
    end else begin
      t.sensor_triggered = !want_level;
    end
    case ($urandom_range(0, 9))
      0:       t.position = 32'h7FFF_FFFF;
      1:       t.position = 32'h8000_0000;
      default: t.position = $urandom;
    endcase
    send_tick(t);
  endtask

  // Directed homing: requests outside their phases, the whole forward and
  // reverse edge capture, and offsets at the two position extremes.
  task automatic test_homing_sequence();
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'd0, 32'd100));
    // Index in the start phase stays pending until init has been consumed.
    send_tick(make_tick(1'b0, 1'b1, 1'b1, 32'd0, 32'd110));
    send_tick(make_tick(1'b1, 1'b0, 1'b1, 32'd0, 32'd120));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'd0, 32'd130));
    // Waiting for low: a high level is no progress.
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'd0, 32'd140));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'd0, 32'd150));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'd160));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'd170));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'd180));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'd190));
    // From indexed a new run starts in the same tick; init stays pending.
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 32'd0, 32'd200));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'd0, 32'd210));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'h8000_0000, 32'd220));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'h8000_0000, 32'd230));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'h8000_0000, 32'd240));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'h8000_0000, 32'd250));
  endtask

  // Directed timeout rules: elapsed equal to the limit, a negative elapsed
  // time, the first failing tick, recovery from error and a stamp that
  // wraps, ending with an offset that rounds toward minus infinity.
  task automatic test_timeout_rules();
    write_timeout(TIMEOUT_W'(100));
    send_tick(make_tick(1'b0, 1'b1, 1'b1, 32'd0, 32'd1000));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'd0, 32'd1100));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'd0, 32'd900));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'd0, 32'd1101));
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFF0));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'd0, 32'd5));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd10));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'd0, 32'd15));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 32'd0, 32'd20));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF));
  endtask

  // Random homing runs under one timeout setting. With stall_output set the
  // receiver holds off for a long stretch early on while ticks keep coming.
  task automatic test_random_homing(input logic [TIMEOUT_W-1:0] limit,
                                    input logic [31:0] step_max, input int count,
                                    input bit stall_output);
    write_timeout(limit);
    for (int i = 0; i < count; i++) begin
      if (stall_output && i == 10) hold_req = 1'b1;
      send_random_tick(step_max);
    end
  endtask

  // Receiver: segments of random length that are always ready, mostly ready
  // or mostly stalled, plus one long hold-off on request.
  initial begin
    int seg_left;
    int seg_mode;
    int hold_left;
    seg_left  = 0;
    seg_mode  = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
        if (hold_left == 0) hold_req = 1'b0;
      end else if (hold_req) begin
        hold_left = 80;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        case (seg_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    mismatches++;
  endtask

  // Each result taken at an edge is compared with the oldest expectation.
  always @(posedge clk) begin
    hih_result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result with nothing expected, state %0h event %0h", $time,
                 out_ch.fsm_state, out_ch.event_code);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (out_ch.fsm_state !== want.fsm_state)
          report_field("fsm_state", 32'(want.fsm_state), 32'(out_ch.fsm_state));
        if (out_ch.failed !== want.failed)
          report_field("failed", 32'(want.failed), 32'(out_ch.failed));
        if (out_ch.motor_command !== want.motor_command)
          report_field("motor_command", 32'(want.motor_command),
                       32'(out_ch.motor_command));
        if (out_ch.sensor_power !== want.sensor_power)
          report_field("sensor_power", 32'(want.sensor_power),
                       32'(out_ch.sensor_power));
        if (out_ch.event_code !== want.event_code)
          report_field("event_code", 32'(want.event_code), 32'(out_ch.event_code));
        if (out_ch.index_offset !== want.index_offset)
          report_field("index_offset", want.index_offset, out_ch.index_offset);
        if (want.event_code == EV_FOUND) found_seen++;
        if (want.event_code == EV_NOT_FOUND) lost_seen++;
      end
    end
  end

  // Main sequence: reset once, directed checks, then random runs under seven
  // timeout settings including zero, the maximum and the reset value.
  initial begin
    mismatches = 0;
    ticks_sent = 0;
    found_seen = 0;
    lost_seen  = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    clock_ms   = 32'd5000;
    reset_model();
    rst                    <= 1'b1;
    cfg_write              <= 1'b0;
    cfg_data               <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.init_request     <= 1'b0;
    in_ch.index_request    <= 1'b0;
    in_ch.sensor_triggered <= 1'b0;
    in_ch.position         <= '0;
    in_ch.now_ms           <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // The reset timeout of 10000 ms is in force for the directed homing.
    test_homing_sequence();
    test_timeout_rules();
    test_random_homing(TIMEOUT_W'(50), 32'd15, 400, 1'b1);
    test_random_homing(TIMEOUT_W'(0), 32'd3, 300, 1'b0);
    test_random_homing({TIMEOUT_W{1'b1}}, 32'h2000_0000, 300, 1'b0);
    test_random_homing(TIMEOUT_RESET, 32'd3000, 400, 1'b0);
    test_random_homing(TIMEOUT_W'($urandom), 32'd0, 0, 1'b0);
    test_random_homing(timeout_limit, (32'(timeout_limit) >> 2) + 32'd1, 300, 1'b0);
    test_random_homing(TIMEOUT_W'($urandom_range(1, 400)), 32'd60, 300, 1'b0);

    pause_until_drained();
    repeat (4) @(posedge clk);
    $display("Ran %0d ticks over seven timeout settings: %0d index found, %0d not found.",
             ticks_sent, found_seen, lost_seen);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
